FILE: rtl/fla_pkg.sv
// Shared types and constants for the free-list index allocator.
// Holds the command and result payload structs and the controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps

package fla_pkg;

  // Fixed field widths of the command and result payloads.
  localparam int SLOT_W  = 12;
  localparam int GRANT_W = 10;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } fla_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } fla_status_t;

  typedef struct packed {
    fla_op_t             command;
    logic [SLOT_W-1:0]   slot_index;
  } fla_in_t;

  typedef struct packed {
    logic [GRANT_W-1:0]  granted_index;
    fla_status_t         status;
  } fla_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming command
    logic execute;   // evaluate the latched command
    logic pop_done;  // stack read data is ready
  } fla_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_pending;  // latched command is an allocate served from the stack
  } fla_sts_t;

endpackage

FILE: rtl/free_list_index_allocator.sv
// Top level of the free-list index allocator: LIFO free stack in front of a bump counter.
// Depends on fla_pkg, fla_ctrl, fla_dp and (through fla_dp) fla_ram.
//
//   Channel | Ports                      | Transfer when
//   --------+----------------------------+-------------------------------
//   command | start, busy, in_data       | start high and busy low
//   result  | out_valid, out_data        | out_valid high (one cycle)
//
// A command passes from its accepting edge through the execute state to the result
// register; an allocate that pops the free stack also waits in the pop state, as the
// stack RAM has a registered read port. Busy is already low while the result
// strobe is shown, so the next command can be accepted at the same edge that
// ends that strobe. Reset is synchronous and active low; it
// empties the stack and restarts the bump counter, and needs no clearing pass
// since stack entries are only read below the fill count. The result side
// cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module free_list_index_allocator #(
  parameter int POOL_SIZE = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fla_pkg::fla_in_t  in_data,
  output logic              out_valid,
  output fla_pkg::fla_out_t out_data
);

  // Control and status between the sequencer and the datapath.
  fla_pkg::fla_ctl_t ctl;
  fla_pkg::fla_sts_t sts;

  // The controller walks each command through capture, execute and, for a
  // stack pop, a wait for the RAM read data.
  fla_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // The datapath holds the free stack, the fill count, the bump counter and
  // the result register that drives the output strobe.
  fla_dp #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/fla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/fla_ctrl.sv
// Sequencing state machine for the free-list index allocator.
// Depends on fla_pkg for the controller/datapath interface structs.
`timescale 1ns / 1ps

module fla_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  fla_pkg::fla_sts_t sts,
  output fla_pkg::fla_ctl_t ctl,
  output logic              busy
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_POP  = 3'b100
  } fla_state_t;

  fla_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = sts.pop_pending ? S_POP : S_IDLE;
      end
      S_POP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign ctl.capture  = start && (state_r == S_IDLE);
  assign ctl.execute  = (state_r == S_EXEC);
  assign ctl.pop_done = (state_r == S_POP);

endmodule

FILE: rtl/fla_dp.sv
// Datapath of the free-list index allocator: free stack RAM, counters and result register.
// Depends on fla_pkg and fla_ram.
`timescale 1ns / 1ps

module fla_dp #(
  parameter int POOL_SIZE = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fla_pkg::fla_in_t  in_data,
  input  fla_pkg::fla_ctl_t ctl,
  output fla_pkg::fla_sts_t sts,
  output logic              out_valid,
  output fla_pkg::fla_out_t out_data
);

  localparam int          AW     = $clog2(POOL_SIZE);
  localparam int          CW     = $clog2(POOL_SIZE + 1);
  localparam logic [CW-1:0] POOL_C = CW'(POOL_SIZE);
  localparam logic [31:0] POOL_W = 32'(POOL_SIZE);

  fla_pkg::fla_op_t                 op_r;
  logic [fla_pkg::SLOT_W-1:0]       idx_r;
  logic [CW-1:0]                    count_r, count_nxt;
  logic [CW-1:0]                    fresh_r, fresh_nxt;
  logic                             out_valid_r, out_valid_nxt;
  fla_pkg::fla_out_t                out_data_r, out_data_nxt;

  logic                             is_alloc;
  logic                             nonempty;
  logic                             full;
  logic                             out_of_range;
  logic                             fresh_avail;
  logic                             ram_we;
  logic                             ram_re;
  logic [AW-1:0]                    ram_waddr;
  logic [AW-1:0]                    ram_raddr;
  logic [fla_pkg::GRANT_W-1:0]      ram_rdata;

  assign is_alloc     = (op_r == fla_pkg::CMD_ALLOC);
  assign nonempty     = (count_r != '0);
  assign full         = (count_r == POOL_C);
  assign fresh_avail  = (fresh_r != POOL_C);
  assign out_of_range = (32'(idx_r) >= POOL_W);

  assign sts.pop_pending = is_alloc && nonempty;

  // Pop reads the top entry; push writes just above it.
  assign ram_re    = ctl.execute && sts.pop_pending;
  assign ram_raddr = AW'(count_r - CW'(1));
  assign ram_we    = ctl.execute && !is_alloc && !out_of_range && !full;
  assign ram_waddr = AW'(count_r);

  fla_ram #(
    .WIDTH (fla_pkg::GRANT_W),
    .DEPTH (POOL_SIZE)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (fla_pkg::GRANT_W'(idx_r)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    count_nxt     = count_r;
    fresh_nxt     = fresh_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    if (ctl.execute) begin
      if (sts.pop_pending) begin
        count_nxt = count_r - CW'(1);
      end else begin
        out_valid_nxt              = 1'b1;
        out_data_nxt.granted_index = '0;
        out_data_nxt.status        = fla_pkg::ST_OK;
        if (is_alloc) begin
          if (fresh_avail) begin
            out_data_nxt.granted_index = fla_pkg::GRANT_W'(fresh_r);
            fresh_nxt                  = fresh_r + CW'(1);
          end else begin
            out_data_nxt.status = fla_pkg::ST_EXHAUSTED;
          end
        end else if (out_of_range) begin
          out_data_nxt.status = fla_pkg::ST_RANGE;
        end else if (full) begin
          out_data_nxt.status = fla_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
    end

    if (ctl.pop_done) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.granted_index = ram_rdata;
      out_data_nxt.status        = fla_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_r  <= in_data.command;
      idx_r <= in_data.slot_index;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: sim/free_list_index_allocator_tb.sv
// Self-checking testbench for free_list_index_allocator: random and directed allocate/free
// traffic, with every result checked against a behavioral model of the stack and bump counter.
// Depends on fla_pkg and the free_list_index_allocator RTL.
`timescale 1ns / 1ps

module free_list_index_allocator_tb;

  localparam int POOL_SIZE      = 1024;
  localparam int RANDOM_ITEMS   = 690;
  // Even the slowest command with the longest random gap stays far below this limit,
  // so reaching it can only mean the block has stopped answering.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;

  logic              clk   = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  fla_pkg::fla_in_t  in_data = '0;
  logic              out_valid;
  fla_pkg::fla_out_t out_data;

  free_list_index_allocator #(
    .POOL_SIZE(POOL_SIZE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // Commands waiting to be driven, and results waiting to be seen.
  fla_pkg::fla_in_t  pending_cmds[$];
  fla_pkg::fla_out_t expected_results[$];

  int error_count    = 0;
  int accepted_count = 0;
  int total_items    = 0;
  int gap_left       = 0;
  bit calm           = 1'b0;

  // Shadow of the allocator state, advanced once per accepted command.
  logic [fla_pkg::GRANT_W-1:0] free_slots[POOL_SIZE];
  int unsigned                 slot_depth = 0;
  int unsigned                 fresh_next = 0;

  // Computes the result of one command and updates the shadow state. An
  // allocate pops the newest freed index first and only then touches the bump
  // counter; a free is rejected when out of range or when the stack is full.
  function automatic fla_pkg::fla_out_t allocator_step(fla_pkg::fla_in_t cmd);
    fla_pkg::fla_out_t res;
    res.granted_index = '0;
    res.status        = fla_pkg::ST_OK;
    if (cmd.command == fla_pkg::CMD_ALLOC) begin
      if (slot_depth > 0) begin
        slot_depth--;
        res.granted_index = free_slots[slot_depth];
      end else if (fresh_next < POOL_SIZE) begin
        res.granted_index = fla_pkg::GRANT_W'(fresh_next);
        fresh_next++;
      end else begin
        res.status = fla_pkg::ST_EXHAUSTED;
      end
    end else begin
      if (cmd.slot_index >= POOL_SIZE) begin
        res.status = fla_pkg::ST_RANGE;
      end else if (slot_depth >= POOL_SIZE) begin
        res.status = fla_pkg::ST_FULL;
      end else begin
        free_slots[slot_depth] = cmd.slot_index[fla_pkg::GRANT_W-1:0];
        slot_depth++;
      end
    end
    return res;
  endfunction

  // Queues one command at the back of the pending list.
  task automatic queue_cmd(fla_pkg::fla_op_t op, logic [fla_pkg::SLOT_W-1:0] idx);
    fla_pkg::fla_in_t c;
    c.command    = op;
    c.slot_index = idx;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // Driver. A transfer takes place at an edge where start is high and busy is
  // low; after it the driver waits a random number of cycles, zero inside calm
  // stretches, before offering the next command.
  always @(posedge clk) begin
    fla_pkg::fla_in_t next_cmd;
    if (!rst_n) begin
      start    <= 1'b0;
      in_data  <= '0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        expected_results.insert(expected_results.size(), allocator_step(in_data));
        accepted_count++;
        gap_left = calm ? 0 : $urandom_range(0, 5);
        if ($urandom_range(0, 39) == 0) calm = !calm;
      end
      // The channel is free unless a command is still being offered.
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          next_cmd = pending_cmds.pop_front();
          in_data  <= next_cmd;
          start    <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each strobe is one result transfer and is matched against the
  // oldest outstanding expectation.
  always @(posedge clk) begin
    fla_pkg::fla_out_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual granted_index %0d status %0d",
                 $time, out_data.granted_index, out_data.status);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.granted_index !== want.granted_index) begin
          $display("%0t: granted_index mismatch, expected %0d, actual %0d",
                   $time, want.granted_index, out_data.granted_index);
          error_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_data.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transfer.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int kind;
    int len;
    int n;
    int same_idx;

    // Directed part: first fresh grants, reuse in last-in-first-out order,
    // range limits of a free, and allocates carrying junk in slot_index.
    queue_cmd(fla_pkg::CMD_ALLOC, 12'd0);
    queue_cmd(fla_pkg::CMD_ALLOC, 12'hFFF);
    queue_cmd(fla_pkg::CMD_FREE,  12'd1);
    queue_cmd(fla_pkg::CMD_FREE,  12'd0);
    queue_cmd(fla_pkg::CMD_ALLOC, 12'hAAA);
    queue_cmd(fla_pkg::CMD_ALLOC, 12'h555);
    queue_cmd(fla_pkg::CMD_ALLOC, 12'd0);
    queue_cmd(fla_pkg::CMD_FREE,  12'hFFF);
    queue_cmd(fla_pkg::CMD_FREE,  12'd1024);
    queue_cmd(fla_pkg::CMD_FREE,  12'd1023);
    queue_cmd(fla_pkg::CMD_FREE,  12'hAAA);
    queue_cmd(fla_pkg::CMD_FREE,  12'h155);
    queue_cmd(fla_pkg::CMD_FREE,  12'h2AA);
    queue_cmd(fla_pkg::CMD_ALLOC, 12'd0);
    queue_cmd(fla_pkg::CMD_ALLOC, 12'd0);
    queue_cmd(fla_pkg::CMD_ALLOC, 12'd0);
    // A double free is accepted and hands the same index out twice.
    queue_cmd(fla_pkg::CMD_FREE,  12'd2);
    queue_cmd(fla_pkg::CMD_FREE,  12'd2);
    queue_cmd(fla_pkg::CMD_ALLOC, 12'd0);
    queue_cmd(fla_pkg::CMD_ALLOC, 12'd0);
    queue_cmd(fla_pkg::CMD_ALLOC, 12'd0);

    // Random part, in bursts so that the stack both deepens and drains.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 40);
      same_idx = $urandom_range(0, POOL_SIZE - 1);
      for (int i = 0; i < len; i++) begin
        if (kind <= 3) begin
          queue_cmd(fla_pkg::CMD_ALLOC, fla_pkg::SLOT_W'($urandom_range(0, 4095)));
        end else if (kind <= 6) begin
          queue_cmd(fla_pkg::CMD_FREE, fla_pkg::SLOT_W'($urandom_range(0, POOL_SIZE - 1)));
        end else if (kind <= 8) begin
          if ($urandom_range(0, 1) == 0)
            queue_cmd(fla_pkg::CMD_ALLOC, fla_pkg::SLOT_W'($urandom_range(0, 4095)));
          else if ($urandom_range(0, 7) == 0)
            queue_cmd(fla_pkg::CMD_FREE, fla_pkg::SLOT_W'($urandom_range(POOL_SIZE, 4095)));
          else
            queue_cmd(fla_pkg::CMD_FREE, fla_pkg::SLOT_W'($urandom_range(0, POOL_SIZE - 1)));
        end else begin
          queue_cmd(fla_pkg::CMD_FREE, fla_pkg::SLOT_W'(same_idx));
        end
      end
      n += len;
    end

    // Closing mixed traffic, with frees drawn over the whole index field.
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(0, 1) == 0)
        queue_cmd(fla_pkg::CMD_ALLOC, fla_pkg::SLOT_W'($urandom_range(0, 4095)));
      else
        queue_cmd(fla_pkg::CMD_FREE, fla_pkg::SLOT_W'($urandom_range(0, 4095)));
    end

    total_items = pending_cmds.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    wait (accepted_count == total_items);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
